// File: rtl/ga_pkg.sv
// shared types and codes for the grid a-star first-step block
`default_nettype none
package ga_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // neighbour directions in the order they are tried
  localparam logic [1:0] DIR_PY = 2'd0;
  localparam logic [1:0] DIR_PX = 2'd1;
  localparam logic [1:0] DIR_MY = 2'd2;
  localparam logic [1:0] DIR_MX = 2'd3;

  typedef struct packed {
    logic start;
    logic pop;
    logic flush;
  } ga_heap_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ga_heap_rsp_t;

endpackage
`default_nettype wire

// File: rtl/ga_cmd_if.sv
// input channel: obstacle writes and path queries
`default_nettype none
interface ga_cmd_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic       cell_blocked;
  logic [5:0] start_x;
  logic [5:0] start_y;
  logic [5:0] goal_x;
  logic [5:0] goal_y;

  modport source (output valid, opcode, cell_x, cell_y, cell_blocked, start_x, start_y,
                  goal_x, goal_y, input ready);
  modport sink (input valid, opcode, cell_x, cell_y, cell_blocked, start_x, start_y,
                goal_x, goal_y, output ready);
endinterface
`default_nettype wire

// File: rtl/ga_res_if.sv
// output channel: first step of the found path
`default_nettype none
interface ga_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] next_x;
  logic [5:0] next_y;
  logic       path_found;
  logic       open_overflow;

  modport source (output valid, next_x, next_y, path_found, open_overflow, input ready);
  modport sink (input valid, next_x, next_y, path_found, open_overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/grid_astar_first_step.sv
// top level: obstacle map, closed and parent stores, and the search sequencer
//
// cmd carries two kinds of transaction. opcode write sets or clears one cell of the
// obstacle map and produces no result. opcode query runs an a-star search from start
// to goal on the 4-connected grid and produces exactly one result transaction on res:
// the first cell of the path, or the start cell, with the found and overflow flags.
// a query first sweeps the closed marks, one cell a cycle, then expands cells one at
// a time; the open list lives in one memory, sifted a level at a time, and the
// path is walked back from the goal one cell at a time. cmd.ready is high only while
// the sequencer is idle. after reset a sweep over every cell clears the obstacle map
// before the first transaction is taken.
// the result sits in an output register; cmd can take writes and the next query while
// it waits, and a query that finishes while the register is still full holds until
// the receiver takes the earlier result.
`default_nettype none
module grid_astar_first_step import ga_pkg::*; #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64,
  parameter int OPEN_DEPTH  = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  ga_cmd_if.sink    cmd,
  ga_res_if.source  res
);

  localparam int XB     = $clog2(GRID_WIDTH);
  localparam int YB     = $clog2(GRID_HEIGHT);
  localparam int XYB    = (XB > YB) ? XB : YB;
  localparam int KX     = (XYB > 6) ? XYB : 6;
  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int IW     = $clog2(CELLS);
  localparam int GW     = IW + 1;
  localparam int FW     = ((GW > KX + 1) ? GW : KX + 1) + 1;
  localparam int SW     = $clog2(4 * CELLS + 1) + 1;
  localparam int KEY_W  = FW + SW;
  localparam int DATA_W = 2 * KX + GW + 2;
  localparam int EW     = KEY_W + DATA_W;
  localparam int CW     = $clog2(OPEN_DEPTH) + 1;

  typedef struct packed {
    logic [FW-1:0] f;
    logic [SW-1:0] seq;
    logic [KX-1:0] x;
    logic [KX-1:0] y;
    logic [GW-1:0] g;
    logic [1:0]    dir;
  } ent_t;

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_QCLR  = 14'b00000000000100,
    S_START = 14'b00000000001000,
    S_STW   = 14'b00000000010000,
    S_POP   = 14'b00000000100000,
    S_POPW  = 14'b00000001000000,
    S_CHK   = 14'b00000010000000,
    S_NB    = 14'b00000100000000,
    S_NBR   = 14'b00001000000000,
    S_NBW   = 14'b00010000000000,
    S_TR    = 14'b00100000000000,
    S_TRR   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state;

  logic          obst    [CELLS];
  logic          closed  [CELLS];
  logic [1:0]    parent  [CELLS];
  logic          obst_rd;
  logic          closed_rd;
  logic [1:0]    parent_rd;

  logic [IW-1:0] clr_idx;
  logic [KX-1:0] sx, sy, gx, gy;
  ent_t          cur;
  logic [IW-1:0] cidx;
  logic [1:0]    d;
  logic [KX-1:0] nx, ny;
  logic [KX-1:0] tx, ty;
  logic [SW-1:0] seq;
  logic          found, overflow;
  logic [KX-1:0] out_x, out_y;

  ga_heap_req_t    hreq;
  ga_heap_rsp_t    hrsp;
  logic [EW-1:0]   hpush;
  logic [EW-1:0]   htop;
  logic [CW-1:0]   hcount;
  ent_t            top_e;
  ent_t            push_e;

  ga_heap #(
    .DEPTH  (OPEN_DEPTH),
    .KEY_W  (KEY_W),
    .DATA_W (DATA_W)
  ) u_heap (
    .clk        (clk),
    .rst        (rst),
    .req        (hreq),
    .push_entry (hpush),
    .top_entry  (htop),
    .count      (hcount),
    .rsp        (hrsp)
  );

  assign top_e = ent_t'(htop);
  assign hpush = EW'(push_e);

  // write-port cell, popped cell, neighbour cell and trace cell indexes
  logic [KX-1:0] wx, wy;
  logic [IW-1:0] widx, pidx, nb_idx, tidx;
  logic          w_in_grid;
  assign wx        = KX'(cmd.cell_x);
  assign wy        = KX'(cmd.cell_y);
  assign w_in_grid = (32'(wx) < 32'(GRID_WIDTH)) && (32'(wy) < 32'(GRID_HEIGHT));
  assign widx   = IW'(32'(wy) * 32'(GRID_WIDTH) + 32'(wx));
  assign pidx   = IW'(32'(top_e.y) * 32'(GRID_WIDTH) + 32'(top_e.x));
  assign tidx   = IW'(32'(ty) * 32'(GRID_WIDTH) + 32'(tx));

  // neighbour of the current cell in direction d
  logic [KX:0] nbx, nby;
  logic        nb_in;
  always_comb begin
    nbx = {1'b0, cur.x};
    nby = {1'b0, cur.y};
    case (d)
      DIR_PY:  nby = {1'b0, cur.y} + (KX+1)'(1);
      DIR_PX:  nbx = {1'b0, cur.x} + (KX+1)'(1);
      DIR_MY:  nby = {1'b0, cur.y} - (KX+1)'(1);
      DIR_MX:  nbx = {1'b0, cur.x} - (KX+1)'(1);
      default: ;
    endcase
  end
  assign nb_in  = (32'(nbx) < 32'(GRID_WIDTH)) && (32'(nby) < 32'(GRID_HEIGHT));
  assign nb_idx = IW'(32'(nby) * 32'(GRID_WIDTH) + 32'(nbx));

  // walk one step back along the stored parent direction
  logic [KX:0] bkx, bky;
  logic        bk_in;
  always_comb begin
    bkx = {1'b0, tx};
    bky = {1'b0, ty};
    case (parent_rd)
      DIR_PY:  bky = {1'b0, ty} - (KX+1)'(1);
      DIR_PX:  bkx = {1'b0, tx} - (KX+1)'(1);
      DIR_MY:  bky = {1'b0, ty} + (KX+1)'(1);
      DIR_MX:  bkx = {1'b0, tx} + (KX+1)'(1);
      default: ;
    endcase
  end
  assign bk_in = (32'(bkx) < 32'(GRID_WIDTH)) && (32'(bky) < 32'(GRID_HEIGHT));

  // heuristic and cost for the entry to push
  logic [KX-1:0] hx, hy, ax, ay;
  logic [GW-1:0] pg;
  always_comb begin
    hx = (state == S_START) ? sx : nx;
    hy = (state == S_START) ? sy : ny;
    ax = (gx > hx) ? gx - hx : hx - gx;
    ay = (gy > hy) ? gy - hy : hy - gy;
    pg = (state == S_START) ? '0 : cur.g + GW'(1);
    push_e.f   = FW'(pg) + FW'(ax) + FW'(ay);
    push_e.seq = seq;
    push_e.x   = hx;
    push_e.y   = hy;
    push_e.g   = pg;
    push_e.dir = (state == S_START) ? DIR_PY : d;
  end

  logic cmd_fire, start_in;
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign start_in  = (32'(cmd.start_x) < 32'(GRID_WIDTH)) &&
                     (32'(cmd.start_y) < 32'(GRID_HEIGHT));

  logic nb_push;
  assign nb_push = (state == S_NBR) && !obst_rd && !closed_rd && (hcount != CW'(OPEN_DEPTH));

  always_comb begin
    hreq.flush = (state == S_QCLR);
    hreq.pop   = (state == S_POP);
    hreq.start = (state == S_START) || nb_push || ((state == S_POP) && (hcount != '0));
  end

  // memory ports
  logic [IW-1:0] obst_ra, closed_ra;
  assign obst_ra   = nb_idx;
  assign closed_ra = (state == S_POPW) ? pidx : nb_idx;

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      obst[clr_idx] <= 1'b0;
    end else if (cmd_fire && cmd.opcode == OP_WRITE && w_in_grid) begin
      obst[widx] <= cmd.cell_blocked;
    end
    obst_rd <= obst[obst_ra];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLR || state == S_QCLR) begin
      closed[clr_idx] <= 1'b0;
    end else if (state == S_CHK && !closed_rd) begin
      closed[cidx] <= 1'b1;
    end
    closed_rd <= closed[closed_ra];
  end

  always_ff @(posedge clk) begin
    if (state == S_CHK && !closed_rd) begin
      parent[cidx] <= cur.dir;
    end
    parent_rd <= parent[tidx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      res.valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_CLR, S_QCLR: begin
          if (clr_idx == IW'(CELLS - 1)) begin
            clr_idx <= '0;
            state   <= (state == S_CLR) ? S_IDLE : S_START;
          end else begin
            clr_idx <= clr_idx + IW'(1);
          end
        end
        S_IDLE: begin
          if (cmd_fire && cmd.opcode == OP_QUERY) begin
            state <= start_in ? S_QCLR : S_FIN;
          end
        end
        S_START: state <= S_STW;
        S_STW:   if (hrsp.done) state <= S_POP;
        S_POP:   state <= (hcount == '0) ? S_FIN : S_POPW;
        S_POPW:  if (hrsp.done) state <= S_CHK;
        S_CHK: begin
          if (closed_rd) begin
            state <= S_POP;
          end else if (cur.x == gx && cur.y == gy) begin
            state <= (gx != sx || gy != sy) ? S_TR : S_FIN;
          end else begin
            state <= S_NB;
          end
        end
        S_NB: begin
          if (nb_in) begin
            state <= S_NBR;
          end else if (d == DIR_MX) begin
            state <= S_POP;
          end
        end
        S_NBR: begin
          if (nb_push) begin
            state <= S_NBW;
          end else if (!obst_rd && !closed_rd) begin
            state <= S_FIN;
          end else begin
            state <= (d == DIR_MX) ? S_POP : S_NB;
          end
        end
        S_NBW: if (hrsp.done) state <= (d == DIR_MX) ? S_POP : S_NB;
        S_TR:  state <= S_TRR;
        S_TRR: begin
          if (!bk_in || (bkx[KX-1:0] == sx && bky[KX-1:0] == sy)) begin
            state <= S_FIN;
          end else begin
            state <= S_TR;
          end
        end
        S_FIN: begin
          if (!res.valid || res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sx       <= KX'(cmd.start_x);
        sy       <= KX'(cmd.start_y);
        gx       <= KX'(cmd.goal_x);
        gy       <= KX'(cmd.goal_y);
        out_x    <= KX'(cmd.start_x);
        out_y    <= KX'(cmd.start_y);
        found    <= 1'b0;
        overflow <= 1'b0;
        seq      <= '0;
      end
      S_START: seq <= seq + SW'(1);
      S_POPW: begin
        cur  <= top_e;
        cidx <= pidx;
      end
      S_CHK: begin
        d <= DIR_PY;
        if (!closed_rd && cur.x == gx && cur.y == gy) begin
          found <= 1'b1;
          tx    <= gx;
          ty    <= gy;
        end
      end
      S_NB: begin
        nx   <= nbx[KX-1:0];
        ny   <= nby[KX-1:0];
        if (!nb_in) begin
          d <= d + 2'd1;
        end
      end
      S_NBR: begin
        if (nb_push) begin
          seq <= seq + SW'(1);
        end else if (!obst_rd && !closed_rd) begin
          overflow <= 1'b1;
        end else begin
          d <= d + 2'd1;
        end
      end
      S_NBW: if (hrsp.done) d <= d + 2'd1;
      S_TRR: begin
        if (bk_in && bkx[KX-1:0] == sx && bky[KX-1:0] == sy) begin
          out_x <= tx;
          out_y <= ty;
        end
        tx <= bkx[KX-1:0];
        ty <= bky[KX-1:0];
      end
      S_FIN: begin
        if (!res.valid || res.ready) begin
          res.next_x        <= out_x[5:0];
          res.next_y        <= out_y[5:0];
          res.path_found    <= found;
          res.open_overflow <= overflow;
        end
      end
      default: ;
    endcase
  end

  a_no_both_flags: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.path_found && res.open_overflow))
    else $error("found and overflow both set");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == S_FIN))
    else $error("result raised outside finish");

  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    hcount <= CW'(OPEN_DEPTH))
    else $error("open list count beyond depth");

  a_heap_start_idle: assert property (@(posedge clk) disable iff (rst)
    hreq.start |-> !hrsp.busy)
    else $error("heap started while busy");

endmodule
`default_nettype wire

// File: rtl/ga_heap.sv
// binary min-heap open list in a single memory, sifted one level per step
`default_nettype none
module ga_heap import ga_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int KEY_W  = 16,
  parameter int DATA_W = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ga_heap_req_t                  req,
  input  wire logic [KEY_W+DATA_W-1:0]       push_entry,
  output      logic [KEY_W+DATA_W-1:0]       top_entry,
  output      logic [$clog2(DEPTH):0]        count,
  output      ga_heap_rsp_t                  rsp
);

  localparam int EW    = KEY_W + DATA_W;
  localparam int OW    = $clog2(DEPTH);
  localparam int CW    = OW + 1;
  localparam int IDX_W = OW + 2;

  typedef enum logic [7:0] {
    H_IDLE = 8'b00000001,
    H_PUP  = 8'b00000010,
    H_PCMP = 8'b00000100,
    H_Q1   = 8'b00001000,
    H_Q2   = 8'b00010000,
    H_SL   = 8'b00100000,
    H_SLW  = 8'b01000000,
    H_SRW  = 8'b10000000
  } hstate_t;

  hstate_t state, state_next;

  logic [EW-1:0]    mem [DEPTH];
  logic [EW-1:0]    rdata;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [EW-1:0]    wdata;

  logic [EW-1:0]    ent;
  logic [EW-1:0]    lent;
  logic [IDX_W-1:0] idx;
  logic             done;

  logic [IDX_W-1:0] parent_idx;
  logic [IDX_W-1:0] left_idx;
  logic [IDX_W-1:0] right_idx;
  logic [IDX_W-1:0] count_ext;
  logic             left_wins;
  logic [EW-1:0]    cand;

  assign parent_idx = (idx - IDX_W'(1)) >> 1;
  assign left_idx   = {idx[IDX_W-2:0], 1'b1};
  assign right_idx  = left_idx + IDX_W'(1);
  assign count_ext  = IDX_W'(count);
  assign left_wins  = lent[EW-1 -: KEY_W] < ent[EW-1 -: KEY_W];
  assign cand       = left_wins ? lent : ent;

  assign rsp.busy = (state != H_IDLE);
  assign rsp.done = done;

  always_comb begin
    state_next = state;
    raddr      = '0;
    we         = 1'b0;
    waddr      = idx;
    wdata      = ent;
    case (state)
      H_IDLE: begin
        if (req.start && req.pop) begin
          state_next = H_Q1;
        end else if (req.start) begin
          state_next = H_PUP;
        end
      end
      H_PUP: begin
        if (idx == '0) begin
          we         = 1'b1;
          state_next = H_IDLE;
        end else begin
          raddr      = parent_idx;
          state_next = H_PCMP;
        end
      end
      H_PCMP: begin
        we = 1'b1;
        if (ent[EW-1 -: KEY_W] < rdata[EW-1 -: KEY_W]) begin
          wdata      = rdata;
          state_next = H_PUP;
        end else begin
          state_next = H_IDLE;
        end
      end
      H_Q1: begin
        raddr = count_ext - IDX_W'(1);
        if (count == CW'(1)) begin
          state_next = H_IDLE;
        end else begin
          state_next = H_Q2;
        end
      end
      H_Q2: state_next = H_SL;
      H_SL: begin
        if (left_idx >= count_ext) begin
          we         = 1'b1;
          state_next = H_IDLE;
        end else begin
          raddr      = left_idx;
          state_next = H_SLW;
        end
      end
      H_SLW: begin
        if (right_idx < count_ext) begin
          raddr      = right_idx;
          state_next = H_SRW;
        end else begin
          we = 1'b1;
          if (rdata[EW-1 -: KEY_W] < ent[EW-1 -: KEY_W]) begin
            wdata      = rdata;
            state_next = H_SL;
          end else begin
            state_next = H_IDLE;
          end
        end
      end
      H_SRW: begin
        we = 1'b1;
        if (rdata[EW-1 -: KEY_W] < cand[EW-1 -: KEY_W]) begin
          wdata      = rdata;
          state_next = H_SL;
        end else if (left_wins) begin
          wdata      = lent;
          state_next = H_SL;
        end else begin
          state_next = H_IDLE;
        end
      end
      default: state_next = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[OW-1:0]] <= wdata;
    end
    rdata <= mem[raddr[OW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state != H_IDLE) && (state_next == H_IDLE);
      if (state == H_IDLE && req.flush) begin
        count <= '0;
      end else if (state == H_IDLE && req.start && !req.pop) begin
        count <= count + CW'(1);
      end else if (state == H_Q1) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        if (req.start && !req.pop) begin
          ent <= push_entry;
          idx <= count_ext;
        end
      end
      H_PCMP: begin
        if (ent[EW-1 -: KEY_W] < rdata[EW-1 -: KEY_W]) begin
          idx <= parent_idx;
        end
      end
      H_Q1: top_entry <= rdata;
      H_Q2: begin
        ent <= rdata;
        idx <= '0;
      end
      H_SLW: begin
        lent <= rdata;
        if (right_idx >= count_ext && rdata[EW-1 -: KEY_W] < ent[EW-1 -: KEY_W]) begin
          idx <= left_idx;
        end
      end
      H_SRW: begin
        if (rdata[EW-1 -: KEY_W] < cand[EW-1 -: KEY_W]) begin
          idx <= right_idx;
        end else if (left_wins) begin
          idx <= left_idx;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the grid a-star first-step block
`timescale 1ns / 1ps
module testbench;
  import ga_pkg::*;

  localparam int GRID_W     = 64;
  localparam int GRID_H     = 64;
  localparam int CELLS      = GRID_W * GRID_H;
  localparam int OPEN_DEPTH = 4096;
  localparam int N_RANDOM   = 80;
  localparam int MAX_EXPAND = 400;
  localparam int LONG_HOLD  = 40000;
  localparam longint CYCLE_LIMIT = 40000000;

  typedef struct packed {
    logic [5:0] nx;
    logic [5:0] ny;
    logic       found;
    logic       ovf;
  } first_step_t;

  typedef struct {
    logic        op;
    logic [5:0]  cx, cy;
    logic        cb;
    logic [5:0]  sx, sy, gx, gy;
    bit          typed;
    first_step_t want;
  } cmd_row_t;

  typedef struct {
    int unsigned x, y, g, f, seq;
    logic [1:0]  dir;
  } open_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ga_cmd_if cmd_ch();
  ga_res_if res_ch();

  grid_astar_first_step u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  bit          obst_map[CELLS];
  bit          closed_map[CELLS];
  logic [1:0]  came_dir[CELLS];
  open_entry_t open_heap[OPEN_DEPTH];
  int unsigned open_cnt;
  int unsigned push_seq;

  first_step_t pending_steps[$];
  int          errors = 0;
  int          steps_seen = 0;
  int          cmds_sent;
  int          queries_sent;
  longint      cycles = 0;
  bit          hold_req;
  cmd_row_t    dir_rows[$];

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR t=%0t %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void step_of(logic [1:0] d, output int dx, output int dy);
    dx = 0;
    dy = 0;
    case (d)
      DIR_PY: dy = 1;
      DIR_PX: dx = 1;
      DIR_MY: dy = -1;
      DIR_MX: dx = -1;
      default: ;
    endcase
  endfunction

  function automatic int unsigned abs_gap(int unsigned a, int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit earlier(open_entry_t a, open_entry_t b);
    if (a.f != b.f) return a.f < b.f;
    return a.seq < b.seq;
  endfunction

  function automatic bit open_push(int unsigned x, int unsigned y, int unsigned g,
                                   int unsigned f, logic [1:0] d);
    open_entry_t e;
    int unsigned i, p;
    if (open_cnt >= OPEN_DEPTH) return 1'b0;
    e.x = x; e.y = y; e.g = g; e.f = f; e.dir = d; e.seq = push_seq++;
    i = open_cnt++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!earlier(e, open_heap[p])) break;
      open_heap[i] = open_heap[p];
      i = p;
    end
    open_heap[i] = e;
    return 1'b1;
  endfunction

  function automatic open_entry_t open_pop();
    open_entry_t top, last;
    int unsigned i, l, r, m;
    bit use_l;
    top = open_heap[0];
    open_cnt--;
    if (open_cnt == 0) return top;
    last = open_heap[open_cnt];
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      use_l = 1'b0;
      if (l < open_cnt && earlier(open_heap[l], last)) begin
        m = l;
        use_l = 1'b1;
      end
      if (r < open_cnt && earlier(open_heap[r], use_l ? open_heap[l] : last)) m = r;
      if (m == i) break;
      open_heap[i] = open_heap[m];
      i = m;
    end
    open_heap[i] = last;
    return top;
  endfunction

  // runs the search and also reports how many cells were expanded
  function automatic first_step_t plan_first_step(int unsigned sx, int unsigned sy,
                                                  int unsigned gx, int unsigned gy,
                                                  output int expanded);
    first_step_t r;
    open_entry_t cur;
    bit done;
    int c, nx, ny, dx, dy, cx, cy, px, py, guard;
    int unsigned g;
    r.nx = sx[5:0]; r.ny = sy[5:0]; r.found = 1'b0; r.ovf = 1'b0;
    expanded = 0;
    done = 1'b0;
    foreach (closed_map[k]) closed_map[k] = 1'b0;
    open_cnt = 0;
    push_seq = 0;
    void'(open_push(sx, sy, 0, abs_gap(gx, sx) + abs_gap(gy, sy), 2'd0));
    while (open_cnt > 0 && !done) begin
      cur = open_pop();
      c = cur.y * GRID_W + cur.x;
      if (closed_map[c]) continue;
      came_dir[c] = cur.dir;
      if (cur.x == gx && cur.y == gy) begin
        r.found = 1'b1;
        if (gx != sx || gy != sy) begin
          cx = gx; cy = gy;
          for (guard = 0; guard < CELLS; guard++) begin
            step_of(came_dir[cy * GRID_W + cx], dx, dy);
            px = cx - dx;
            py = cy - dy;
            if (px < 0 || py < 0 || px >= GRID_W || py >= GRID_H) break;
            if (px == sx && py == sy) begin
              r.nx = cx[5:0];
              r.ny = cy[5:0];
              break;
            end
            cx = px; cy = py;
          end
        end
        break;
      end
      closed_map[c] = 1'b1;
      expanded++;
      for (int d = 0; d < 4; d++) begin
        step_of(d[1:0], dx, dy);
        nx = cur.x + dx;
        ny = cur.y + dy;
        if (nx < 0 || nx >= GRID_W || ny < 0 || ny >= GRID_H) continue;
        if (obst_map[ny * GRID_W + nx] || closed_map[ny * GRID_W + nx]) continue;
        g = cur.g + 1;
        if (!open_push(nx, ny, g, g + abs_gap(gx, nx) + abs_gap(gy, ny), d[1:0])) begin
          r.ovf = 1'b1;
          done = 1'b1;
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic cmd_row_t mk_write(int x, int y, bit b);
    cmd_row_t r;
    r.op = OP_WRITE; r.cx = 6'(x); r.cy = 6'(y); r.cb = b;
    r.sx = 6'($urandom); r.sy = 6'($urandom); r.gx = 6'($urandom); r.gy = 6'($urandom);
    r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic cmd_row_t mk_query(int sx, int sy, int gx, int gy, bit typed,
                                        first_step_t want);
    cmd_row_t r;
    r.op = OP_QUERY; r.cx = 6'($urandom); r.cy = 6'($urandom); r.cb = 1'($urandom);
    r.sx = 6'(sx); r.sy = 6'(sy); r.gx = 6'(gx); r.gy = 6'(gy);
    r.typed = typed; r.want = want;
    return r;
  endfunction

  task automatic send_cmd(cmd_row_t r, int gap);
    first_step_t p;
    int ex;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= r.op;
    cmd_ch.cell_x       <= r.cx;
    cmd_ch.cell_y       <= r.cy;
    cmd_ch.cell_blocked <= r.cb;
    cmd_ch.start_x      <= r.sx;
    cmd_ch.start_y      <= r.sy;
    cmd_ch.goal_x       <= r.gx;
    cmd_ch.goal_y       <= r.gy;
    do @(posedge clk); while (!cmd_ch.ready);
    // transaction taken at this edge
    cmds_sent++;
    if (r.op == OP_WRITE) begin
      obst_map[r.cy * GRID_W + r.cx] = r.cb;
    end else begin
      queries_sent++;
      p = plan_first_step(r.sx, r.sy, r.gx, r.gy, ex);
      pending_steps.push_back(r.typed ? r.want : p);
    end
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  function automatic int clip(int v);
    return (v < 0) ? 0 : (v > 63) ? 63 : v;
  endfunction

  // result side: random back-pressure plus one long hold-off on request
  int stall_left;
  bit hold_taken = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 49) == 0) stall_left = $urandom_range(1, 4);
        else if ($urandom_range(0, 1999) == 0) stall_left = $urandom_range(50, 500);
      end
    end
  end

  always @(posedge clk) begin
    first_step_t w;
    if (!rst && res_ch.valid && res_ch.ready) begin
      steps_seen++;
      if (pending_steps.size() == 0) begin
        report_mismatch("unexpected result next_x", res_ch.next_x, -1);
      end else begin
        w = pending_steps.pop_front();
        if (res_ch.next_x !== w.nx) report_mismatch("next_x", res_ch.next_x, w.nx);
        if (res_ch.next_y !== w.ny) report_mismatch("next_y", res_ch.next_y, w.ny);
        if (res_ch.path_found !== w.found)
          report_mismatch("path_found", res_ch.path_found, w.found);
        if (res_ch.open_overflow !== w.ovf)
          report_mismatch("open_overflow", res_ch.open_overflow, w.ovf);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_astar_first_step: mismatch");
      $finish;
    end
  end

  initial begin
    cmd_row_t r;
    first_step_t p;
    int sx, sy, gx, gy, ex, tries, big_left;
    cmds_sent = 0; queries_sent = 0;
    hold_req = 1'b0;
    foreach (obst_map[k]) obst_map[k] = 1'b0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.opcode       <= OP_WRITE;
    cmd_ch.cell_x       <= '0;
    cmd_ch.cell_y       <= '0;
    cmd_ch.cell_blocked <= 1'b0;
    cmd_ch.start_x      <= '0;
    cmd_ch.start_y      <= '0;
    cmd_ch.goal_x       <= '0;
    cmd_ch.goal_y       <= '0;

    // directed rows
    dir_rows.push_back(mk_query(5, 5, 5, 5, 1, '{6'd5, 6'd5, 1'b1, 1'b0}));
    dir_rows.push_back(mk_query(0, 0, 0, 1, 1, '{6'd0, 6'd1, 1'b1, 1'b0}));
    dir_rows.push_back(mk_query(63, 63, 63, 62, 1, '{6'd63, 6'd62, 1'b1, 1'b0}));
    dir_rows.push_back(mk_query(0, 0, 63, 63, 0, '0));
    dir_rows.push_back(mk_query(63, 0, 0, 63, 0, '0));
    // blocked start, then a detour round a wall
    dir_rows.push_back(mk_write(10, 10, 1));
    dir_rows.push_back(mk_query(10, 10, 10, 12, 0, '0));
    dir_rows.push_back(mk_write(10, 11, 1));
    dir_rows.push_back(mk_query(10, 10, 10, 12, 0, '0));
    // blocked goal searches the whole grid and fails
    dir_rows.push_back(mk_write(20, 20, 1));
    dir_rows.push_back(mk_query(20, 21, 20, 20, 1, '{6'd20, 6'd21, 1'b0, 1'b0}));
    dir_rows.push_back(mk_write(20, 20, 0));
    dir_rows.push_back(mk_query(20, 21, 20, 20, 1, '{6'd20, 6'd20, 1'b1, 1'b0}));
    // walled-in start gives no path quickly
    dir_rows.push_back(mk_write(30, 31, 1));
    dir_rows.push_back(mk_write(31, 30, 1));
    dir_rows.push_back(mk_write(30, 29, 1));
    dir_rows.push_back(mk_write(29, 30, 1));
    dir_rows.push_back(mk_query(30, 30, 32, 30, 1, '{6'd30, 6'd30, 1'b0, 1'b0}));
    // blocked start that equals the goal
    dir_rows.push_back(mk_write(63, 63, 1));
    dir_rows.push_back(mk_query(63, 63, 63, 63, 1, '{6'd63, 6'd63, 1'b1, 1'b0}));
    dir_rows.push_back(mk_write(63, 63, 0));
    dir_rows.push_back(mk_write(10, 10, 0));
    dir_rows.push_back(mk_write(10, 11, 0));
    dir_rows.push_back(mk_write(30, 31, 0));
    dir_rows.push_back(mk_write(31, 30, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_cmd(dir_rows[i], pick_gap());

    big_left = 1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 30) hold_req = 1'b1;
      if (n == 60) begin
        cmd_ch.valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 40) begin
        r = mk_write($urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 99) < 60);
      end else begin
        sx = $urandom_range(0, 63);
        sy = $urandom_range(0, 63);
        // keep searches short unless one long one is still allowed
        for (tries = 0; tries < 8; tries++) begin
          if ($urandom_range(0, 9) == 0) begin
            gx = $urandom_range(0, 63);
            gy = $urandom_range(0, 63);
          end else begin
            gx = clip(sx + $urandom_range(0, 12) - 6);
            gy = clip(sy + $urandom_range(0, 12) - 6);
          end
          p = plan_first_step(sx, sy, gx, gy, ex);
          if (ex <= MAX_EXPAND) break;
          if (big_left > 0) begin
            big_left--;
            break;
          end
        end
        if (tries == 8) begin
          gx = sx;
          gy = sy;
        end
        r = mk_query(sx, sy, gx, gy, 0, '0);
      end
      send_cmd(r, pick_gap());
    end
    cmd_ch.valid <= 1'b0;

    while (pending_steps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d transactions (%0d queries), %0d results checked",
             cmds_sent, queries_sent, steps_seen);
    $display("with obstacle writes, blocked and walled-in cells and output back-pressure");
    if (errors == 0 && pending_steps.size() == 0) begin
      $display("grid_astar_first_step: match");
    end else begin
      $display("grid_astar_first_step: mismatch");
    end
    $finish;
  end

endmodule
